/* src/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants and types for the binary Tanimoto similarity block.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Input words are carried 64 bits wide; lanes split a word into bytes
  localparam int WORD_MAX  = 64;
  localparam int LANE_BITS = 8;
  localparam int LANES     = WORD_MAX / LANE_BITS;
  localparam int LANE_CW   = $clog2(LANE_BITS + 1);

  // Quotient bits: one integer bit plus 17 fraction bits before rounding
  localparam int QBITS = 18;
  localparam int QCW   = $clog2(QBITS);
  localparam int SIM_W = 17;

  // Output tdata width: similarity padded to whole bytes
  localparam int OUT_DATA_W = ((SIM_W + 7) / 8) * 8;

  typedef struct packed {
    logic [LANE_CW-1:0] and_cnt;
    logic [LANE_CW-1:0] or_cnt;
  } lane_cnt_t;

endpackage

/* src/bts_lane.sv */
// ----------------------------------------------------------------------------
// bts_lane
// One byte lane: registered popcounts of a AND b and a OR b.
// ----------------------------------------------------------------------------
module bts_lane (
  input  logic                           clk,
  input  logic                           load,
  input  logic [bts_pkg::LANE_BITS-1:0]  a,
  input  logic [bts_pkg::LANE_BITS-1:0]  b,
  output bts_pkg::lane_cnt_t             cnt
);

  bts_pkg::lane_cnt_t cnt_next;

  always_comb begin
    cnt_next = '0;
    for (int i = 0; i < bts_pkg::LANE_BITS; i++) begin
      cnt_next.and_cnt = cnt_next.and_cnt + bts_pkg::LANE_CW'(a[i] & b[i]);
      cnt_next.or_cnt  = cnt_next.or_cnt  + bts_pkg::LANE_CW'(a[i] | b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_next;
    end
  end

endmodule

/* src/bts_merge.sv */
// ----------------------------------------------------------------------------
// bts_merge
// Sums the lane counts of one word and keeps saturating running totals.
// Hands the totals of a pair to the divider on the last word.
// ----------------------------------------------------------------------------
module bts_merge #(
  parameter int FP_BITS = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     stage_valid,
  input  logic                                     stage_last,
  input  bts_pkg::lane_cnt_t [bts_pkg::LANES-1:0]  cnts,
  input  logic                                     fin_ready,
  output logic                                     consume,
  output logic                                     fin_valid,
  output logic [$clog2(FP_BITS+1)-1:0]             fin_and,
  output logic [$clog2(FP_BITS+1)-1:0]             fin_or
);

  localparam int CW    = $clog2(FP_BITS + 1);
  localparam int INC_W = $clog2(bts_pkg::LANES * bts_pkg::LANE_BITS + 1);

  logic [CW-1:0]    acc_and;
  logic [CW-1:0]    acc_or;
  logic [INC_W-1:0] and_inc;
  logic [INC_W-1:0] or_inc;
  logic [CW:0]      and_sum;
  logic [CW:0]      or_sum;

  always_comb begin
    and_inc = '0;
    or_inc  = '0;
    for (int i = 0; i < bts_pkg::LANES; i++) begin
      and_inc = and_inc + INC_W'(cnts[i].and_cnt);
      or_inc  = or_inc  + INC_W'(cnts[i].or_cnt);
    end
  end

  assign and_sum = (CW+1)'(acc_and) + (CW+1)'(and_inc);
  assign or_sum  = (CW+1)'(acc_or)  + (CW+1)'(or_inc);

  // saturate at the fingerprint length
  assign fin_and = (and_sum > (CW+1)'(FP_BITS)) ? CW'(FP_BITS) : and_sum[CW-1:0];
  assign fin_or  = (or_sum  > (CW+1)'(FP_BITS)) ? CW'(FP_BITS) : or_sum[CW-1:0];

  // a last word waits until the divider is free
  assign consume   = stage_valid && (!stage_last || fin_ready);
  assign fin_valid = stage_valid && stage_last && fin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_and <= '0;
      acc_or  <= '0;
    end else if (consume) begin
      if (stage_last) begin
        acc_and <= '0;
        acc_or  <= '0;
      end else begin
        acc_and <= fin_and;
        acc_or  <= fin_or;
      end
    end
  end

  as_and_within_or: assert property (@(posedge clk) disable iff (rst)
    acc_and <= acc_or)
    else $error("AND total exceeds OR total");

endmodule

/* src/bts_div.sv */
// ----------------------------------------------------------------------------
// bts_div
// Forms the ratio of a finished pair and divides it one quotient bit a
// cycle; rounds to Q1.16 and holds the result in the output register.
// ----------------------------------------------------------------------------
module bts_div #(
  parameter int FP_BITS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               average_mode,
  input  logic                               fin_valid,
  input  logic [$clog2(FP_BITS+1)-1:0]       fin_and,
  input  logic [$clog2(FP_BITS+1)-1:0]       fin_or,
  output logic                               fin_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bts_pkg::SIM_W-1:0]          out_sim,
  output logic                               out_empty
);

  localparam int CW = $clog2(FP_BITS + 1);
  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;
  localparam int RW = DW + 1;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_SUM  = 5'b00100,
    F_DIV  = 5'b01000,
    F_OUT  = 5'b10000
  } fin_state_t;

  fin_state_t                 state;
  logic [CW-1:0]              p;
  logic [CW-1:0]              q;
  logic [PW-1:0]              prod_ps;
  logic [PW-1:0]              prod_rq;
  logic [PW-1:0]              prod_qs;
  logic [DW-1:0]              divisor;
  logic [RW-1:0]              rem;
  logic [bts_pkg::QBITS-1:0]  quo;
  logic [bts_pkg::QCW-1:0]    step;
  logic                       empty_r;

  logic [CW-1:0]              s_raw;
  logic [CW-1:0]              s_val;
  logic [CW-1:0]              r_val;
  logic                       rem_ge;
  logic [RW-1:0]              rem_sub;
  logic [bts_pkg::QBITS-1:0]  quo_inc;
  logic                       out_free;

  // complemented term: an empty complemented union counts as zero
  assign s_raw = CW'(FP_BITS) - p;
  assign s_val = (s_raw == '0) ? CW'(1) : s_raw;
  assign r_val = (s_raw == '0) ? '0 : (CW'(FP_BITS) - q);

  assign rem_ge  = rem >= RW'(divisor);
  assign rem_sub = rem_ge ? (rem - RW'(divisor)) : rem;

  // round half up: drop the extra quotient bit after adding one
  assign quo_inc = quo + bts_pkg::QBITS'(1);

  assign fin_ready = (state == F_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      out_valid <= 1'b0;
    end else begin
      // F_OUT reloads the register in the cycle it drains
      if (out_valid && out_ready && state != F_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        F_IDLE: begin
          if (fin_valid) begin
            p       <= fin_and;
            q       <= fin_or;
            empty_r <= (fin_or == '0);
            state   <= (fin_or == '0) ? F_OUT : F_MUL;
          end
        end
        F_MUL: begin
          prod_ps <= PW'(p) * PW'(s_val);
          prod_rq <= PW'(r_val) * PW'(q);
          prod_qs <= PW'(q) * PW'(s_val);
          state   <= F_SUM;
        end
        F_SUM: begin
          // (p/q + r/s)/2 = (p*s + r*q) / (2*q*s)
          if (average_mode) begin
            rem     <= RW'(DW'(prod_ps) + DW'(prod_rq));
            divisor <= {prod_qs, 1'b0};
          end else begin
            rem     <= RW'(p);
            divisor <= DW'(q);
          end
          quo   <= '0;
          step  <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          quo  <= {quo[bts_pkg::QBITS-2:0], rem_ge};
          rem  <= {rem_sub[RW-2:0], 1'b0};
          step <= step + bts_pkg::QCW'(1);
          if (step == bts_pkg::QCW'(bts_pkg::QBITS - 1)) begin
            state <= F_OUT;
          end
        end
        F_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_sim   <= empty_r ? '0 : quo_inc[bts_pkg::QBITS-1:1];
            out_empty <= empty_r;
            state     <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  as_sim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_sim <= bts_pkg::SIM_W'(65536))
    else $error("similarity above 1.0");

  as_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_empty |-> out_sim == '0)
    else $error("empty union with nonzero similarity");

  as_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == F_DIV |-> rem < {divisor, 1'b0})
    else $error("divider remainder out of range");

  as_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> state == F_IDLE)
    else $error("pair handed over while divider busy");

endmodule

/* src/binary_tanimoto_similarity.sv */
// ----------------------------------------------------------------------------
// binary_tanimoto_similarity
// Tanimoto similarity of two binary fingerprints streamed as word pairs.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    tdata: word_a, word_b; tlast: last_word
// m_       out  m_tvalid / m_tready    tdata: similarity; tuser: union_empty
// cfg_     in   cfg_valid / cfg_ready  cfg_data: average_mode
//
// Words are taken one a cycle; the byte lanes register their popcounts and
// the merge stage adds them into the running totals. A last word starts the
// divider: it loads the pair, forms the products, sets up the division, finds
// one quotient bit a step and loads the output register. Words of the next
// pair keep flowing meanwhile; its last word waits for the divider.
// Reset clears the totals, the divider state and average_mode.
// ----------------------------------------------------------------------------
module binary_tanimoto_similarity #(
  parameter int FP_BITS   = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [2*bts_pkg::WORD_MAX-1:0]     s_tdata,  // word_a, word_b
  input  logic                               s_tlast,  // last_word
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bts_pkg::OUT_DATA_W-1:0]     m_tdata,  // similarity, zero pad
  output logic                               m_tuser,  // union_empty
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data  // average_mode
);

  localparam int CW = $clog2(FP_BITS + 1);
  localparam logic [bts_pkg::WORD_MAX-1:0] WORD_MASK =
    (WORD_BITS >= bts_pkg::WORD_MAX) ? '1 :
    ((bts_pkg::WORD_MAX'(1) << WORD_BITS) - bts_pkg::WORD_MAX'(1));

  logic                                     average_mode;
  logic                                     stage_valid;
  logic                                     stage_last;
  logic                                     load;
  logic                                     consume;
  logic                                     fin_valid;
  logic                                     fin_ready;
  logic [CW-1:0]                            fin_and;
  logic [CW-1:0]                            fin_or;
  logic [bts_pkg::WORD_MAX-1:0]             word_a;
  logic [bts_pkg::WORD_MAX-1:0]             word_b;
  bts_pkg::lane_cnt_t [bts_pkg::LANES-1:0]  cnts;
  logic [bts_pkg::SIM_W-1:0]                sim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_mode <= 1'b0;
    end else if (cfg_valid) begin
      average_mode <= cfg_data;
    end
  end

  // drop bits above the fingerprint word width
  assign word_a = s_tdata[bts_pkg::WORD_MAX-1:0] & WORD_MASK;
  assign word_b = s_tdata[2*bts_pkg::WORD_MAX-1:bts_pkg::WORD_MAX] & WORD_MASK;

  assign s_tready = !stage_valid || consume;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (consume) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_last <= s_tlast;
    end
  end

  for (genvar g = 0; g < bts_pkg::LANES; g++) begin : g_lane
    bts_lane u_lane (
      .clk  (clk),
      .load (load),
      .a    (word_a[g*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS]),
      .b    (word_b[g*bts_pkg::LANE_BITS +: bts_pkg::LANE_BITS]),
      .cnt  (cnts[g])
    );
  end

  bts_merge #(
    .FP_BITS (FP_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_last  (stage_last),
    .cnts        (cnts),
    .fin_ready   (fin_ready),
    .consume     (consume),
    .fin_valid   (fin_valid),
    .fin_and     (fin_and),
    .fin_or      (fin_or)
  );

  bts_div #(
    .FP_BITS (FP_BITS)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .average_mode (average_mode),
    .fin_valid    (fin_valid),
    .fin_and      (fin_and),
    .fin_or       (fin_or),
    .fin_ready    (fin_ready),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_sim      (sim),
    .out_empty    (m_tuser)
  );

  assign m_tdata = bts_pkg::OUT_DATA_W'(sim);

endmodule
